/* hdl/move_to_front_lru_table_defines.svh */
// ----------------------------------------------------------------------------
// move_to_front_lru_table assertion macros
// Shared property forms for the table's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LRU_TABLE_DEFINES_SVH
`define MOVE_TO_FRONT_LRU_TABLE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define MTFLRU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTFLRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mtflru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtflru_pkg
// Types, codes and default sizes for the move-to-front lru table.
// ----------------------------------------------------------------------------
package mtflru_pkg;

   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int OWNER_W = 8;
   localparam int COUNT_W = 7;

   localparam int ENTRIES_DEF    = 64;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP    = 2'd0,
      FUNC_INSTALL   = 2'd1,
      FUNC_UNINSTALL = 2'd2
   } func_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic take_prev;
      logic take_next;
   } cell_ctrl_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value_handle;
      logic [OWNER_W-1:0] owner_id;
   } req_item_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value_out;
      logic               evicted;
      logic [COUNT_W-1:0] entry_count;
   } rsp_item_type;

endpackage

/* hdl/mtflru_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtflru_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mtflru_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

/* hdl/mtflru_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtflru_cell
// One table slot: holds an entry, compares it against a request and loads
// from either neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module mtflru_cell #(
   parameter int KEY_BITS = mtflru_pkg::KEY_BITS_DEF,
   parameter int VAL_BITS = mtflru_pkg::VALUE_W,
   localparam int VAL_LO    = mtflru_pkg::OWNER_W,
   localparam int KEY_LO    = VAL_LO + VAL_BITS,
   localparam int VALID_BIT = KEY_LO + KEY_BITS,
   localparam int ENTRY_W   = VALID_BIT + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmp_en,
   input  logic [mtflru_pkg::FUNC_W-1:0]   cmp_func,
   input  logic [KEY_BITS-1:0]             cmp_key,
   input  logic [VAL_BITS-1:0]             cmp_value,
   input  logic [mtflru_pkg::OWNER_W-1:0]  cmp_owner,
   input  mtflru_pkg::cell_ctrl_type       ctrl,
   input  logic [ENTRY_W-1:0]              prev_entry,
   input  logic [ENTRY_W-1:0]              next_entry,
   output logic [ENTRY_W-1:0]              entry,
   output logic                            match
);

   logic                           valid_ff, valid_in;
   logic [KEY_BITS-1:0]            key_ff, key_in;
   logic [VAL_BITS-1:0]            value_ff, value_in;
   logic [mtflru_pkg::OWNER_W-1:0] owner_ff, owner_in;
   logic                           match_ff, match_in;
   logic [ENTRY_W-1:0]             load_entry;

   always_comb begin
      case (cmp_func)
         mtflru_pkg::FUNC_LOOKUP:    match_in = (key_ff == cmp_key) && (owner_ff == cmp_owner);
         mtflru_pkg::FUNC_INSTALL:   match_in = (key_ff == cmp_key);
         mtflru_pkg::FUNC_UNINSTALL: match_in = (value_ff == cmp_value);
         default:                    match_in = 1'b0;
      endcase
      match_in = match_in && valid_ff && cmp_en;
   end

   assign load_entry = ctrl.take_prev ? prev_entry : next_entry;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      owner_in = owner_ff;
      if (ctrl.take_prev || ctrl.take_next) begin
         valid_in = load_entry[VALID_BIT];
         key_in   = load_entry[VALID_BIT-1:KEY_LO];
         value_in = load_entry[KEY_LO-1:VAL_LO];
         owner_in = load_entry[VAL_LO-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         // compare result is captured only with the request transfer
         if (cmp_en) begin
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      owner_ff <= owner_in;
   end

   assign entry = {valid_ff, key_ff, value_ff, owner_ff};
   assign match = match_ff;

endmodule

/* hdl/mtflru_ctrl.sv */
`timescale 1ns / 1ps
`include "move_to_front_lru_table_defines.svh"
// ----------------------------------------------------------------------------
// mtflru_ctrl
// Sequencer for the cell chain: takes requests, picks the first matching
// cell, steers the shift and keeps the entry count and the response register.
// ----------------------------------------------------------------------------
module mtflru_ctrl #(
   parameter int ENTRIES  = mtflru_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = mtflru_pkg::KEY_BITS_DEF,
   parameter int VAL_BITS = mtflru_pkg::VALUE_W,
   localparam int VAL_LO    = mtflru_pkg::OWNER_W,
   localparam int KEY_LO    = VAL_LO + VAL_BITS,
   localparam int VALID_BIT = KEY_LO + KEY_BITS,
   localparam int ENTRY_W   = VALID_BIT + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   mtflru_stream_if.sink               req_if,
   mtflru_stream_if.source             rsp_if,
   output logic                        cmp_en,
   input  logic [ENTRIES-1:0]          match_vec,
   input  logic [ENTRY_W-1:0]          entries [ENTRIES],
   output mtflru_pkg::cell_ctrl_type   cell_ctrl [ENTRIES],
   output logic [ENTRY_W-1:0]          front_entry
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   mtflru_pkg::state_type          state_ff, state_in;
   logic [mtflru_pkg::FUNC_W-1:0]  func_ff;
   logic [KEY_BITS-1:0]            key_ff;
   logic [VAL_BITS-1:0]            value_ff;
   logic [mtflru_pkg::OWNER_W-1:0] owner_ff;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   mtflru_pkg::rsp_item_type       rsp_ff, rsp_in;

   logic                           fire;
   logic                           any_hit;
   logic                           full;
   logic [ENTRIES-1:0]             first_vec;
   logic [ENTRIES-1:0]             below_vec;
   logic [ENTRY_W-1:0]             sel_entry;
   logic                           is_lookup, is_install, is_uninstall;

   assign cmp_en = req_if.valid && req_if.ready;
   assign fire   = (state_ff == mtflru_pkg::ST_APPLY) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in     = state_ff;
      req_if.ready = 1'b0;
      case (state_ff)
         mtflru_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               state_in = mtflru_pkg::ST_APPLY;
            end
         end
         mtflru_pkg::ST_APPLY: begin
            if (fire) begin
               state_in = mtflru_pkg::ST_IDLE;
            end
         end
         default: state_in = mtflru_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtflru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         func_ff  <= req_if.payload.func;
         key_ff   <= req_if.payload.key[KEY_BITS-1:0];
         value_ff <= req_if.payload.value_handle[VAL_BITS-1:0];
         owner_ff <= req_if.payload.owner_id;
      end
   end

   // lowest set bit of the match vector and the cells in front of it;
   // with no match every cell counts as in front
   assign first_vec = match_vec & ~(match_vec - ENTRIES'(1));
   assign below_vec = ~match_vec & (match_vec - ENTRIES'(1));
   assign any_hit   = |match_vec;
   assign full      = (count_ff == CNT_W'(ENTRIES));

   assign is_lookup    = (func_ff == mtflru_pkg::FUNC_LOOKUP);
   assign is_install   = (func_ff == mtflru_pkg::FUNC_INSTALL);
   assign is_uninstall = (func_ff == mtflru_pkg::FUNC_UNINSTALL);

   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sel_entry = sel_entry | (entries[i] & {ENTRY_W{first_vec[i]}});
      end
   end

   assign front_entry = is_install ? {1'b1, key_ff, value_ff, owner_ff} : sel_entry;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         cell_ctrl[i].take_prev = fire && (below_vec[i] || first_vec[i])
                                  && (is_install || (is_lookup && any_hit));
         cell_ctrl[i].take_next = fire && is_uninstall && any_hit && !below_vec[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      case (func_ff)
         mtflru_pkg::FUNC_INSTALL: begin
            if (!any_hit && !full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         mtflru_pkg::FUNC_UNINSTALL: begin
            if (any_hit) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      rsp_in.hit         = any_hit && (is_lookup || is_install || is_uninstall);
      rsp_in.value_out   = '0;
      rsp_in.evicted     = is_install && !any_hit && full;
      rsp_in.entry_count = mtflru_pkg::COUNT_W'(count_in);
      if (is_lookup && any_hit) begin
         rsp_in.value_out = mtflru_pkg::VALUE_W'(sel_entry[KEY_LO-1:VAL_LO]);
      end
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   `MTFLRU_ASSERT_NEXT(a_fire_loads_rsp, clock, reset, fire, rsp_valid_ff,
      "response register not loaded after an operation completed")
   `MTFLRU_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(ENTRIES),
      "entry count exceeds table size")
   `MTFLRU_ASSERT_NEXT(a_uninstall_count, clock, reset, fire && is_uninstall && any_hit,
      count_ff == $past(count_ff) - CNT_W'(1),
      "uninstall hit did not shrink the table by one")
   `MTFLRU_ASSERT_NEXT(a_lookup_count, clock, reset, fire && is_lookup,
      count_ff == $past(count_ff),
      "lookup changed the entry count")

endmodule

/* hdl/move_to_front_lru_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_lru_table
// Fully associative key/value/owner table kept in most-recent-first order.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries func (lookup, install, uninstall by value), key,
//   value_handle and owner_id; rsp_if returns hit, value_out, evicted and
//   entry_count, one response per request, in order.
//   Every slot is a cell in a chain. In the cycle of the request transfer all
//   cells compare their entry against the request in parallel and register
//   the result; in the apply state, once the response register is free or
//   draining, the first match is picked and the chain shifts by one place,
//   the cells concerned loading from a neighbor, so a hit or a new entry
//   moves to the front or a removed entry's gap closes; the response register loads with it.
//   A request is taken only in the idle state, so no new one is taken before
//   the last one has shifted, as the compare/shift pair of the chain needs.
//   Reset (synchronous, active high) empties the table: valid bits and the
//   count clear at once, no clearing pass.
//   When the receiver stalls, the response waits in its register; the next
//   request is still taken and compared, and its shift holds until the
//   waiting response has been transferred.
// ----------------------------------------------------------------------------
module move_to_front_lru_table #(
   parameter int ENTRIES    = mtflru_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = mtflru_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = mtflru_pkg::VALUE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   mtflru_stream_if.sink   req_if,
   mtflru_stream_if.source rsp_if
);

   // values wider than the 32-bit field keep only the field's bits
   localparam int VAL_BITS  = (VALUE_BITS < mtflru_pkg::VALUE_W) ? VALUE_BITS
                                                                 : mtflru_pkg::VALUE_W;
   localparam int ENTRY_W   = mtflru_pkg::OWNER_W + VAL_BITS + KEY_BITS + 1;

   logic                      cmp_en;
   logic [ENTRIES-1:0]        match_vec;
   logic [ENTRY_W-1:0]        entries [ENTRIES];
   mtflru_pkg::cell_ctrl_type cell_ctrl [ENTRIES];
   logic [ENTRY_W-1:0]        front_entry;

   mtflru_ctrl #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .VAL_BITS (VAL_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .cmp_en      (cmp_en),
      .match_vec   (match_vec),
      .entries     (entries),
      .cell_ctrl   (cell_ctrl),
      .front_entry (front_entry)
   );

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic [ENTRY_W-1:0] prev_entry;
      logic [ENTRY_W-1:0] next_entry;

      if (g == 0) begin : g_head
         assign prev_entry = front_entry;
      end else begin : g_body
         assign prev_entry = entries[g-1];
      end

      // past the tail the chain feeds an empty entry
      if (g == ENTRIES - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_link
         assign next_entry = entries[g+1];
      end

      mtflru_cell #(
         .KEY_BITS (KEY_BITS),
         .VAL_BITS (VAL_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmp_en     (cmp_en),
         .cmp_func   (req_if.payload.func),
         .cmp_key    (req_if.payload.key[KEY_BITS-1:0]),
         .cmp_value  (req_if.payload.value_handle[VAL_BITS-1:0]),
         .cmp_owner  (req_if.payload.owner_id),
         .ctrl       (cell_ctrl[g]),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[g]),
         .match      (match_vec[g])
      );
   end

endmodule

/* verif/tb_move_to_front_lru_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_to_front_lru_table
// Drives lookups, installs, uninstalls and unused codes, predicts each
// response with a scoreboard copy of the recency-ordered entries and checks
// hit, value_out, evicted and entry_count of every response in order.
// ----------------------------------------------------------------------------
module tb_move_to_front_lru_table;
   import mtflru_pkg::*;

   localparam int                CLK_HALF     = 4;
   localparam int                LRU_DEPTH    = ENTRIES_DEF;
   localparam int                LATENCY      = 2;
   localparam int                DRAIN_CYCLES = 4 * LATENCY;
   localparam int                CYCLE_LIMIT  = 100000;
   localparam int                KEY_POOL_N   = 96;
   localparam int                OWNER_POOL_N = 4;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

   logic clock;
   logic reset;

   mtflru_stream_if #(.payload_type(req_item_type)) req_if ();
   mtflru_stream_if #(.payload_type(rsp_item_type)) rsp_if ();

   move_to_front_lru_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // scoreboard copy of the table, index 0 is the most recent entry
   logic [KEY_W-1:0]   lru_key   [LRU_DEPTH];
   logic [VALUE_W-1:0] lru_value [LRU_DEPTH];
   logic [OWNER_W-1:0] lru_owner [LRU_DEPTH];
   int                 lru_count = 0;

   rsp_item_type       pending_rsp_q [$];
   rsp_item_type       expected_rsp;
   int                 error_count   = 0;
   int                 cycle_count   = 0;
   logic               quiet_stretch = 1'b0;

   logic [KEY_W-1:0]   key_pool      [KEY_POOL_N];
   logic [OWNER_W-1:0] owner_pool    [OWNER_POOL_N];
   logic [VALUE_W-1:0] shared_values [4];

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL move_to_front_lru_table");
         $finish;
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= quiet_stretch || ($urandom_range(99) >= 20);
   end

   function automatic void bring_forward(input int pos);
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      logic [OWNER_W-1:0] o;
      k = lru_key[pos];
      v = lru_value[pos];
      o = lru_owner[pos];
      for (int j = pos; j > 0; j--) begin
         lru_key[j]   = lru_key[j-1];
         lru_value[j] = lru_value[j-1];
         lru_owner[j] = lru_owner[j-1];
      end
      lru_key[0]   = k;
      lru_value[0] = v;
      lru_owner[0] = o;
   endfunction

   function automatic rsp_item_type predict_lru(input req_item_type rq);
      rsp_item_type rs;
      int           pos;
      rs  = '0;
      pos = -1;
      case (rq.func)
         FUNC_LOOKUP: begin
            for (int i = 0; i < lru_count; i++) begin
               if (lru_key[i] == rq.key && lru_owner[i] == rq.owner_id) begin
                  pos = i;
                  break;
               end
            end
            if (pos >= 0) begin
               bring_forward(pos);
               rs.hit       = 1'b1;
               rs.value_out = lru_value[0];
            end
         end
         FUNC_INSTALL: begin
            for (int i = 0; i < lru_count; i++) begin
               if (lru_key[i] == rq.key) begin
                  pos = i;
                  break;
               end
            end
            if (pos >= 0) begin
               // update in place keeps the slot count, no eviction
               lru_value[pos] = rq.value_handle;
               lru_owner[pos] = rq.owner_id;
               bring_forward(pos);
               rs.hit = 1'b1;
            end else begin
               if (lru_count == LRU_DEPTH) begin
                  lru_count--;
                  rs.evicted = 1'b1;
               end
               for (int j = lru_count; j > 0; j--) begin
                  lru_key[j]   = lru_key[j-1];
                  lru_value[j] = lru_value[j-1];
                  lru_owner[j] = lru_owner[j-1];
               end
               lru_key[0]   = rq.key;
               lru_value[0] = rq.value_handle;
               lru_owner[0] = rq.owner_id;
               lru_count++;
            end
         end
         FUNC_UNINSTALL: begin
            for (int i = 0; i < lru_count; i++) begin
               if (lru_value[i] == rq.value_handle) begin
                  pos = i;
                  break;
               end
            end
            if (pos >= 0) begin
               for (int j = pos; j + 1 < lru_count; j++) begin
                  lru_key[j]   = lru_key[j+1];
                  lru_value[j] = lru_value[j+1];
                  lru_owner[j] = lru_owner[j+1];
               end
               lru_count--;
               rs.hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rs.entry_count = lru_count[COUNT_W-1:0];
      return rs;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: response with none pending: expected none, actual %h",
                     $time, rsp_if.payload);
            error_count++;
         end else begin
            expected_rsp = pending_rsp_q.pop_front();
            check_field("hit", expected_rsp.hit, rsp_if.payload.hit);
            check_field("value_out", expected_rsp.value_out, rsp_if.payload.value_out);
            check_field("evicted", expected_rsp.evicted, rsp_if.payload.evicted);
            check_field("entry_count", expected_rsp.entry_count, rsp_if.payload.entry_count);
         end
      end
   end

   // valid stays high between back-to-back transfers; lowered only for a gap
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v, input logic [OWNER_W-1:0] o);
      req_item_type item;
      item.func         = f;
      item.key          = k;
      item.value_handle = v;
      item.owner_id     = o;
      if (!quiet_stretch && $urandom_range(99) < 20) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp_q.push_back(predict_lru(item));
   endtask

   task automatic wait_all_results();
      req_if.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [KEY_W-1:0] k_ones;
      logic [KEY_W-1:0] k_edge;
      k_ones = '1;
      k_edge = {1'b1, {(KEY_W-2){1'b0}}, 1'b1};
      // empty table paths
      send_item(FUNC_LOOKUP, '0, '0, '0);
      send_item(FUNC_UNINSTALL, '0, '0, '0);
      send_item(FUNC_UNUSED, k_ones, '1, '1);
      // field extremes
      send_item(FUNC_INSTALL, k_ones, '1, 8'hff);
      send_item(FUNC_INSTALL, '0, '0, 8'h00);
      send_item(FUNC_LOOKUP, k_ones, '0, 8'hff);
      // key matches, owner does not
      send_item(FUNC_LOOKUP, k_ones, '0, 8'h00);
      send_item(FUNC_LOOKUP, '0, '0, 8'hff);
      // install on existing key replaces value and owner
      send_item(FUNC_INSTALL, '0, 32'h5a5a_a5a5, 8'h81);
      send_item(FUNC_LOOKUP, '0, '0, 8'h81);
      send_item(FUNC_LOOKUP, '0, '0, 8'h00);
      // duplicate value, first in recency order is removed
      send_item(FUNC_INSTALL, k_edge, 32'h5a5a_a5a5, 8'h7f);
      send_item(FUNC_UNINSTALL, '0, 32'h5a5a_a5a5, '0);
      send_item(FUNC_LOOKUP, '0, '0, 8'h81);
      send_item(FUNC_LOOKUP, k_edge, '0, 8'h7f);
      send_item(FUNC_UNINSTALL, '0, 32'h1234_5678, '0);
      send_item(FUNC_UNUSED, k_ones, '1, 8'hff);
      send_item(FUNC_UNINSTALL, k_ones, '1, 8'hff);
      send_item(FUNC_UNINSTALL, '0, 32'h5a5a_a5a5, '0);
      send_item(FUNC_LOOKUP, '0, '0, 8'h81);
   endtask

   task automatic test_fill_and_evict();
      logic [KEY_W-1:0] early_keys [4];
      logic [KEY_W-1:0] k;
      int               idx;
      for (int i = 0; i < 90; i++) begin
         if (i % 6 == 5 && lru_count > 0) begin
            idx = $urandom_range(lru_count - 1);
            send_item(FUNC_LOOKUP, lru_key[idx], '0, lru_owner[idx]);
         end else begin
            k = {$urandom, $urandom};
            if (i < 4) early_keys[i] = k;
            send_item(FUNC_INSTALL, k, $urandom, OWNER_W'($urandom));
         end
      end
      for (int i = 0; i < 4; i++) begin
         send_item(FUNC_LOOKUP, early_keys[i], '0, OWNER_W'($urandom));
      end
   endtask

   task automatic random_mix(input int n, input int lookup_pct, input int install_pct,
                             input int uninstall_pct);
      logic [FUNC_W-1:0]  f;
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      logic [OWNER_W-1:0] o;
      int                 roll;
      int                 idx;
      repeat (n) begin
         roll = $urandom_range(99);
         k    = key_pool[$urandom_range(KEY_POOL_N - 1)];
         v    = $urandom;
         o    = owner_pool[$urandom_range(OWNER_POOL_N - 1)];
         if ($urandom_range(9) == 0) o = OWNER_W'($urandom);
         if (roll < lookup_pct) begin
            f = FUNC_LOOKUP;
            if (lru_count > 0 && $urandom_range(99) < 65) begin
               idx = $urandom_range(lru_count - 1);
               k   = lru_key[idx];
               if ($urandom_range(99) < 80) o = lru_owner[idx];
            end
         end else if (roll < lookup_pct + install_pct) begin
            f = FUNC_INSTALL;
            if ($urandom_range(99) < 15) v = shared_values[$urandom_range(3)];
         end else if (roll < lookup_pct + install_pct + uninstall_pct) begin
            f = FUNC_UNINSTALL;
            if (lru_count > 0 && $urandom_range(99) < 70) begin
               v = lru_value[$urandom_range(lru_count - 1)];
            end
         end else begin
            f = FUNC_UNUSED;
         end
         send_item(f, k, v, o);
      end
   endtask

   task automatic test_balanced_traffic();
      random_mix(400, 40, 35, 20);
   endtask

   task automatic test_pause_until_drained();
      random_mix(30, 40, 40, 15);
      wait_all_results();
      random_mix(30, 40, 40, 15);
   endtask

   task automatic test_back_to_back();
      quiet_stretch = 1'b1;
      random_mix(200, 45, 35, 15);
      quiet_stretch = 1'b0;
   endtask

   task automatic test_shrink_to_empty();
      random_mix(150, 20, 10, 65);
   endtask

   task automatic test_regrow();
      random_mix(170, 35, 45, 15);
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};
      owner_pool[0] = 8'h00;
      owner_pool[1] = 8'hff;
      owner_pool[2] = OWNER_W'($urandom);
      owner_pool[3] = OWNER_W'($urandom);
      shared_values[0] = '0;
      shared_values[1] = '1;
      shared_values[2] = $urandom;
      shared_values[3] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_evict();
      test_balanced_traffic();
      test_pause_until_drained();
      test_back_to_back();
      test_shrink_to_empty();
      test_regrow();

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS move_to_front_lru_table");
      end else begin
         $display("FAIL move_to_front_lru_table");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/mtflru_pkg.sv
hdl/mtflru_stream_if.sv
hdl/mtflru_cell.sv
hdl/mtflru_ctrl.sv
hdl/move_to_front_lru_table.sv
verif/tb_move_to_front_lru_table.sv
